// ----- rtl/sfe_pkg.sv -----
package sfe_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int REG_BITS    = 17;
   localparam int GAIN_BITS   = 17;
   localparam int Q_BITS      = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY  = 17'd65536;
   localparam logic [REG_BITS-1:0]  GAIN_RESET  = 17'd32768;
   localparam logic [REG_BITS-1:0]  DELAY_RESET = 17'd48000;
   localparam int                   ROUND_HALF  = 32768;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [0:0] {
      REG_GAIN  = 1'b0,
      REG_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   // one stored stereo frame of past outputs
   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

endpackage

// ----- rtl/sfe_store.sv -----
module sfe_store import sfe_pkg::*; #(
   parameter int DEPTH     = 131072,
   parameter int ADDR_BITS = 17
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output frame_type            rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  frame_type            wr_data
);

   frame_type mem [DEPTH];
   frame_type rd_data_ff;

   // read-during-write to the same entry returns the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sfe_lane.sv -----
module sfe_lane import sfe_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  sample_type           delayed,
   input  logic [GAIN_BITS-1:0] gain,
   input  sample_type           sample_in,
   output sample_type           sample_out
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] SUM_HI = SUM_BITS'(SAMPLE_HI);
   localparam logic signed [SUM_BITS-1:0] SUM_LO = SUM_BITS'(SAMPLE_LO);

   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   sample_type                  x_ff;
   logic signed [PROD_BITS-1:0] rounded;
   logic signed [SUM_BITS-1:0]  sum;

   assign prod_in = PROD_BITS'(delayed) * PROD_BITS'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         x_ff    <= sample_in;
      end
   end

   // round to nearest, ties upward, then add and clip
   assign rounded = (prod_ff + PROD_BITS'(ROUND_HALF)) >>> Q_BITS;
   assign sum     = SUM_BITS'(rounded) + SUM_BITS'(x_ff);

   always_comb begin
      if (sum > SUM_HI) begin
         sample_out = SAMPLE_HI;
      end else if (sum < SUM_LO) begin
         sample_out = SAMPLE_LO;
      end else begin
         sample_out = sum[SAMPLE_BITS-1:0];
      end
   end

endmodule

// ----- rtl/stereo_feedback_echo_core.sv -----
// An accepted request passes stage A, stage B and the output register before its
// result shows. Throughput: one request per cycle unless rsp_stall or the interlock
// holds it; at an effective delay of one frame it waits for the multiply-add loop to close.
// Reset: gain 0.5, delay 48000 frames, write pointer zero, pipeline empty. The
// store is not swept: a fill mark makes never-written frames read as zero.
module stereo_feedback_echo_core import sfe_pkg::*; #(
   parameter int STORE_DEPTH = 131072
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [REG_BITS-1:0] csr_wdata
);

   localparam int ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int DIST_BITS = ((ADDR_BITS > REG_BITS) ? ADDR_BITS : REG_BITS) + 1;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(STORE_DEPTH - 1);
   localparam logic [DIST_BITS-1:0] DEPTH_DIST = DIST_BITS'(STORE_DEPTH);

   // configuration registers
   logic [GAIN_BITS-1:0] gain_ff;
   logic [REG_BITS-1:0]  delay_ff;
   logic [GAIN_BITS-1:0] gain_eff;

   // write pointer and fill mark
   logic [ADDR_BITS-1:0] wp_ff, wp_in;
   logic                 wrapped_ff, wrapped_in;

   // read address for the incoming request
   logic [DIST_BITS-1:0] delay_ext, wp_ext, span, rp_ext;
   logic [ADDR_BITS-1:0] rp;
   logic                 rp_written;

   // handshake and pipeline control
   logic accept, hazard;
   logic a_ready, a_move, b_ready, b_move, o_ready, rsp_take;
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic o_valid_ff, o_valid_in;

   // stage A: memory read data available
   req_type              a_req_ff;
   logic [ADDR_BITS-1:0] a_wp_ff, a_rp_ff;
   logic                 a_zero_ff;
   frame_type            a_frame;

   // stage B: product registered inside the lanes
   logic [ADDR_BITS-1:0] b_wp_ff;
   frame_type            y_frame;

   // last write, forwarded to a read issued at the same edge
   logic                 wb_valid_ff;
   logic [ADDR_BITS-1:0] wb_addr_ff;
   frame_type            wb_data_ff;

   frame_type            rd_data;
   rsp_type              rsp_ff;

   // ---------------------------------------------------------------------
   // Configuration port; write only while the pipeline is empty. The block itself does not enforce this.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         delay_ff <= DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN:  gain_ff  <= csr_wdata;
            REG_DELAY: delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp gain above unity
   assign gain_eff = (gain_ff > GAIN_UNITY) ? GAIN_UNITY : gain_ff;

   // ---------------------------------------------------------------------
   // Read address: write pointer minus delay, modulo the depth. A delay of
   // zero or at least the depth points at the slot about to be overwritten.
   // ---------------------------------------------------------------------
   assign delay_ext = DIST_BITS'(delay_ff);
   assign wp_ext    = DIST_BITS'(wp_ff);

   always_comb begin
      if (delay_ext == '0 || delay_ext >= DEPTH_DIST) begin
         span = DEPTH_DIST;
      end else begin
         span = delay_ext;
      end
      if (wp_ext >= span) begin
         rp_ext = wp_ext - span;
      end else begin
         rp_ext = wp_ext + DEPTH_DIST - span;
      end
   end

   assign rp = rp_ext[ADDR_BITS-1:0];

   // entries below the write pointer have been assigned since reset
   assign rp_written = wrapped_ff || (rp < wp_ff);

   // ---------------------------------------------------------------------
   // Handshake. Each stage advances when the one after it has room.
   // Interlock: hold a request whose source frame sits in a stage that
   // will not have written it back before this request uses it.
   // ---------------------------------------------------------------------
   assign rsp_take = o_valid_ff && !rsp_stall;
   assign o_ready  = !o_valid_ff || !rsp_stall;
   assign b_move   = b_valid_ff && o_ready;
   assign b_ready  = !b_valid_ff || o_ready;
   assign a_move   = a_valid_ff && b_ready;
   assign a_ready  = !a_valid_ff || b_ready;

   assign hazard = (a_valid_ff && a_wp_ff == rp) ||
                   (b_valid_ff && !o_ready && b_wp_ff == rp);

   assign req_stall = !a_ready || hazard;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Write pointer and fill mark advance once per accepted request.
   // ---------------------------------------------------------------------
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (wp_ff == LAST_ADDR) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage valid flags.
   // ---------------------------------------------------------------------
   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end

      b_valid_in = b_valid_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end

      o_valid_in = o_valid_ff;
      if (b_move) begin
         o_valid_in = 1'b1;
      end else if (rsp_take) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
         if (b_move) begin
            wb_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff  <= req_data;
         a_wp_ff   <= wp_ff;
         a_rp_ff   <= rp;
         a_zero_ff <= !rp_written;
      end
      if (a_move) begin
         b_wp_ff <= a_wp_ff;
      end
      if (b_move) begin
         wb_addr_ff <= b_wp_ff;
         wb_data_ff <= y_frame;
         rsp_ff     <= '{left_out: y_frame.left, right_out: y_frame.right};
      end
   end

   // Select the delayed frame: last write first, then zero for a frame never
   // written since reset, else the memory read.
   always_comb begin
      if (wb_valid_ff && wb_addr_ff == a_rp_ff) begin
         a_frame = wb_data_ff;
      end else if (a_zero_ff) begin
         a_frame = '0;
      end else begin
         a_frame = rd_data;
      end
   end

   // ---------------------------------------------------------------------
   // Echo store: read at acceptance, write back when a result leaves stage B.
   // ---------------------------------------------------------------------
   sfe_store #(
      .DEPTH     (STORE_DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rp),
      .rd_data (rd_data),
      .wr_en   (b_move),
      .wr_addr (b_wp_ff),
      .wr_data (y_frame)
   );

   // one multiply-add lane per channel
   sfe_lane u_lane_left (
      .clock      (clock),
      .advance    (a_move),
      .delayed    (a_frame.left),
      .gain       (gain_eff),
      .sample_in  (a_req_ff.left_in),
      .sample_out (y_frame.left)
   );

   sfe_lane u_lane_right (
      .clock      (clock),
      .advance    (a_move),
      .delayed    (a_frame.right),
      .gain       (gain_eff),
      .sample_in  (a_req_ff.right_in),
      .sample_out (y_frame.right)
   );

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------

   // a frame being read is never the one still waiting in stage B
   a_no_pending_source: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && b_valid_ff |-> a_rp_ff != b_wp_ff)
      else $error("stage A reads a frame not yet written back");

   // a never-written frame cannot match the last write
   a_zero_not_forwarded: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_zero_ff |-> !(wb_valid_ff && wb_addr_ff == a_rp_ff))
      else $error("unwritten frame hit by forwarding");

   // requests in stages A and B occupy consecutive slots
   a_b_consecutive: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && b_valid_ff |->
         ((b_wp_ff == LAST_ADDR && a_wp_ff == '0) ||
          (b_wp_ff != LAST_ADDR && a_wp_ff == b_wp_ff + 1'b1)))
      else $error("pipeline slots out of order");

   // the write pointer stays inside the store
   wp_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> wp_ff <= LAST_ADDR)
      else $error("write pointer beyond store depth");

endmodule
